// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rasterizer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCR_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tcr_pkg.sv -----
// ----------------------------------------------------------------------------
// tcr_pkg
// types and constants shared by the coverage rasterizer modules
// ----------------------------------------------------------------------------
package tcr_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_TRI    = 2'd1,
    ACT_FINISH = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_U   = 3'd0,
    CFG_ORIGIN_V   = 3'd1,
    CFG_SCALE      = 3'd2,
    CFG_ACT_WIDTH  = 3'd3,
    CFG_ACT_HEIGHT = 3'd4
  } cfg_idx_t;

  localparam logic [31:0] SCALE_RESET = 32'd67043328;
  localparam logic [10:0] ACT_SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [2:0] vld;
    logic [2:0] left;
  } edge_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MAP,
    F_AREA,
    F_CLASS,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_EDGE_START,
    B_EDGE_ROW,
    B_EDGE_STEP,
    B_EDGE_END,
    B_SPAN_RD,
    B_SPAN_LD,
    B_FILL,
    B_CNT,
    B_CNT_DRAIN,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ----- rtl/tcr_front.sv -----
// ----------------------------------------------------------------------------
// tcr_front
// accepts items, maps vertices to pixels, classifies and queues commands
// ----------------------------------------------------------------------------
module tcr_front import tcr_pkg::*; #(
  parameter int GRID_SIZE = 1024,
  localparam int CW = $clog2(GRID_SIZE)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   init_done,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [191:0]           in_tdata,
  input  logic [1:0]             in_tuser,
  input  logic [31:0]            origin_u,
  input  logic [31:0]            origin_v,
  input  logic [31:0]            pixel_scale,
  input  logic                   q_full,
  output logic                   push,
  output act_t                   cmd_kind,
  output edge_ctl_t              cmd_edge,
  output logic [2:0][CW-1:0]     cmd_px,
  output logic [2:0][CW-1:0]     cmd_py,
  output logic [CW-1:0]          cmd_ymin,
  output logic [CW-1:0]          cmd_ymax
);

  front_state_t state_r, state_nxt;
  logic [31:0] coord_r [6];
  logic [CW-1:0] pix_r [6];
  logic [2:0] k_r;
  logic [1:0] ph_r;
  act_t kind_r;
  logic signed [32:0] d_r;
  logic pos_r;
  logic [47:0] prod_hi_r, prod_lo_r;
  logic signed [2*CW+1:0] ar1_r, ar2_r;
  logic [CW-1:0] ymin_r, ymax_r;
  edge_ctl_t edge_r;

  logic accept;
  logic [31:0] coord_sel, org_sel;
  logic signed [32:0] d;
  logic [48:0] sum;
  logic [32:0] v;
  logic [CW-1:0] pixv;
  logic [CW-1:0] px [3];
  logic [CW-1:0] py [3];
  logic signed [CW:0] ex1, ey1, ex2, ey2;
  logic signed [2*CW+2:0] area;
  logic [CW-1:0] ymin, ymax;
  logic ccw;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px[i] = pix_r[2*i];
      py[i] = pix_r[2*i+1];
    end
  end

  // vertex mapping datapath
  assign coord_sel = coord_r[k_r];
  assign org_sel   = k_r[0] ? origin_v : origin_u;
  assign d   = $signed({coord_sel[31], coord_sel}) - $signed({org_sel[31], org_sel});
  assign sum = {1'b0, prod_hi_r} + 49'(prod_lo_r[47:16]);
  assign v   = sum[48:16];
  always_comb begin
    if (!pos_r) begin
      pixv = '0;
    end else if (v > 33'(GRID_SIZE - 1)) begin
      pixv = CW'(GRID_SIZE - 1);
    end else begin
      pixv = v[CW-1:0];
    end
  end

  // winding and row range
  assign ex1 = $signed({1'b0, px[1]}) - $signed({1'b0, px[0]});
  assign ey1 = $signed({1'b0, py[1]}) - $signed({1'b0, py[0]});
  assign ex2 = $signed({1'b0, px[2]}) - $signed({1'b0, px[0]});
  assign ey2 = $signed({1'b0, py[2]}) - $signed({1'b0, py[0]});
  assign area = $signed({ar1_r[2*CW+1], ar1_r}) - $signed({ar2_r[2*CW+1], ar2_r});
  assign ccw = area[2*CW+2];

  always_comb begin
    ymin = py[0];
    ymax = py[0];
    for (int i = 1; i < 3; i++) begin
      if (py[i] < ymin) ymin = py[i];
      if (py[i] > ymax) ymax = py[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    push = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_tready = init_done;
        if (accept) begin
          if (in_tuser == ACT_TRI) begin
            state_nxt = F_MAP;
          end else if (in_tuser == ACT_CLEAR || in_tuser == ACT_FINISH) begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_MAP: begin
        if (ph_r == 2'd2 && k_r == 3'd5) state_nxt = F_AREA;
      end
      F_AREA:  state_nxt = F_CLASS;
      F_CLASS: state_nxt = (ymin_r == ymax_r) ? F_IDLE : F_PUSH;
      F_PUSH: begin
        push = !q_full;
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 6; i++) coord_r[i] <= in_tdata[32*i +: 32];
          k_r <= '0;
          ph_r <= '0;
          case (in_tuser)
            ACT_CLEAR: kind_r <= ACT_CLEAR;
            ACT_TRI:   kind_r <= ACT_TRI;
            default:   kind_r <= ACT_FINISH;
          endcase
        end
      end
      F_MAP: begin
        case (ph_r)
          2'd0: begin
            d_r <= d;
            ph_r <= 2'd1;
          end
          2'd1: begin
            pos_r <= !d_r[32] && (d_r != '0);
            prod_hi_r <= 48'(d_r[31:16]) * 48'(pixel_scale);
            prod_lo_r <= 48'(d_r[15:0]) * 48'(pixel_scale);
            ph_r <= 2'd2;
          end
          default: begin
            pix_r[k_r] <= pixv;
            k_r <= k_r + 3'd1;
            ph_r <= 2'd0;
          end
        endcase
      end
      F_AREA: begin
        ar1_r <= ex1 * ey2;
        ar2_r <= ex2 * ey1;
        ymin_r <= ymin;
        ymax_r <= ymax;
      end
      F_CLASS: begin
        for (int i = 0; i < 3; i++) begin
          edge_r.vld[i]  <= py[i] != py[(i + 1) % 3];
          edge_r.left[i] <= (py[(i + 1) % 3] < py[i]) ^ ccw;
        end
      end
      default: ;
    endcase
  end

  assign cmd_kind = kind_r;
  assign cmd_edge = edge_r;
  assign cmd_ymin = ymin_r;
  assign cmd_ymax = ymax_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmd_px[i] = px[i];
      cmd_py[i] = py[i];
    end
  end

endmodule

// ----- rtl/tcr_queue.sv -----
// ----------------------------------------------------------------------------
// tcr_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module tcr_queue import tcr_pkg::*; #(
  parameter int W = 88
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output q_stat_t      stat
);

  logic [W-1:0] mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign rdata = mem_r[rp_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// ----- rtl/tcr_back.sv -----
// ----------------------------------------------------------------------------
// tcr_back
// walks edges, fills spans into the coverage grid, clears and reports
// ----------------------------------------------------------------------------
module tcr_back import tcr_pkg::*; #(
  parameter int GRID_SIZE = 1024,
  localparam int CW = $clog2(GRID_SIZE),
  localparam int DEPTH = GRID_SIZE * GRID_SIZE,
  localparam int AW = $clog2(DEPTH),
  localparam int NW = $clog2(DEPTH + 1),
  localparam int EW = CW + 3
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               init_done,
  input  logic               q_empty,
  output logic               pop,
  input  act_t               cmd_kind,
  input  edge_ctl_t          cmd_edge,
  input  logic [2:0][CW-1:0] cmd_px,
  input  logic [2:0][CW-1:0] cmd_py,
  input  logic [CW-1:0]      cmd_ymin,
  input  logic [CW-1:0]      cmd_ymax,
  input  logic [10:0]        active_width,
  input  logic [10:0]        active_height,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [79:0]        out_tdata
);

  back_state_t state_r, state_nxt;
  logic init_done_r;
  logic [AW-1:0] clr_r;

  logic [1:0] grid_mem [DEPTH];
  logic [CW-1:0] lspan_mem [GRID_SIZE];
  logic [CW-1:0] rspan_mem [GRID_SIZE];
  logic [1:0] gr_q_r;
  logic [CW-1:0] ls_q_r, rs_q_r;

  logic [CW-1:0] px_r [3];
  logic [CW-1:0] py_r [3];
  edge_ctl_t edge_r;
  logic [CW-1:0] ymin_r, ymax_r;
  logic [1:0] ei_r;
  logic [CW-1:0] x_r, y_r, xb_r, yb_r, xr_r, dx_r, dy_r;
  logic sx_neg_r, left_r;
  logic signed [EW-1:0] e_r;

  logic inc_vld_r, cnt_vld_r;
  logic [AW-1:0] inc_addr_r;
  logic [CW:0] w_r, h_r;
  logic [NW-1:0] area_r, fill_r, over_r, remf_r, remo_r;
  logic [4:0] k_r;
  logic [16:0] qf_r, qo_r;
  logic out_vld_r;
  logic [79:0] out_data_r;

  // edge setup
  logic [1:0] ej;
  logic [CW-1:0] xi, yi, xj, yj, xa, ya, xb, yb, dxa, dy;
  logic signed [CW:0] dxs;
  logic sneg;
  logic signed [EW-1:0] e0;
  logic [CW:0] wc, hc;

  logic [AW-1:0] gr_addr, gw_addr;
  logic gw_en;
  logic [1:0] gw_data;
  logic sw_en, sw_left;
  logic [CW-1:0] sw_addr, sw_data;
  logic row_last;
  logic [NW:0] rin_f, rin_o;
  logic ge_f, ge_o;

  function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] y, input logic [CW-1:0] x);
    logic [AW-1:0] a;
    a = AW'(y) * AW'(GRID_SIZE) + AW'(x);
    return a;
  endfunction

  assign init_done = init_done_r;
  assign ej = (ei_r == 2'd2) ? 2'd0 : ei_r + 2'd1;
  assign xi = px_r[ei_r];
  assign yi = py_r[ei_r];
  assign xj = px_r[ej];
  assign yj = py_r[ej];
  assign xa = (yi > yj) ? xj : xi;
  assign ya = (yi > yj) ? yj : yi;
  assign xb = (yi > yj) ? xi : xj;
  assign yb = (yi > yj) ? yi : yj;
  assign dxs = $signed({1'b0, xb}) - $signed({1'b0, xa});
  assign sneg = !(dxs > 0);
  assign dxa = sneg ? CW'(-dxs) : CW'(dxs);
  assign dy = yb - ya;
  assign e0 = $signed(EW'(dy)) - $signed(EW'({dxa, 1'b0}));

  assign wc = (32'(active_width) > 32'(GRID_SIZE)) ? (CW+1)'(GRID_SIZE) : (CW+1)'(active_width);
  assign hc = (32'(active_height) > 32'(GRID_SIZE)) ? (CW+1)'(GRID_SIZE) : (CW+1)'(active_height);

  assign gr_addr = pix_addr(y_r, x_r);
  assign row_last = ({1'b0, y_r} + 1'b1) == {1'b0, ymax_r};

  assign rin_f = (k_r == '0) ? {1'b0, fill_r} : {remf_r, 1'b0};
  assign rin_o = (k_r == '0) ? {1'b0, over_r} : {remo_r, 1'b0};
  assign ge_f = rin_f >= {1'b0, area_r};
  assign ge_o = rin_o >= {1'b0, area_r};

  always_comb begin
    gw_en = 1'b0;
    gw_addr = inc_addr_r;
    gw_data = (gr_q_r == 2'd2) ? 2'd2 : gr_q_r + 2'd1;
    if (state_r == B_CLEAR) begin
      gw_en = 1'b1;
      gw_addr = clr_r;
      gw_data = 2'd0;
    end else if (inc_vld_r) begin
      gw_en = 1'b1;
    end
  end

  always_comb begin
    sw_en = 1'b0;
    sw_left = left_r;
    sw_addr = y_r;
    sw_data = x_r;
    case (state_r)
      B_EDGE_START: begin
        sw_en = (ei_r != 2'd3) && edge_r.vld[ei_r];
        sw_left = edge_r.left[ei_r];
        sw_addr = ya;
        sw_data = xa;
      end
      B_EDGE_STEP: sw_en = !e_r[EW-1];
      B_EDGE_END: begin
        sw_en = 1'b1;
        sw_addr = yb_r;
        sw_data = xb_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pop = 1'b0;
    case (state_r)
      B_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = B_IDLE;
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (cmd_kind)
            ACT_CLEAR: state_nxt = B_CLEAR;
            ACT_TRI:   state_nxt = B_EDGE_START;
            default:   state_nxt = (wc == '0 || hc == '0) ? B_DIV : B_CNT;
          endcase
        end
      end
      B_EDGE_START: begin
        if (ei_r == 2'd3) begin
          state_nxt = B_SPAN_RD;
        end else if (edge_r.vld[ei_r]) begin
          state_nxt = (({1'b0, ya} + 1'b1) < {1'b0, yb}) ? B_EDGE_ROW : B_EDGE_END;
        end
      end
      B_EDGE_ROW: state_nxt = B_EDGE_STEP;
      B_EDGE_STEP: begin
        if (!e_r[EW-1]) begin
          state_nxt = (({1'b0, y_r} + 1'b1) < {1'b0, yb_r}) ? B_EDGE_ROW : B_EDGE_END;
        end
      end
      B_EDGE_END: state_nxt = B_EDGE_START;
      B_SPAN_RD:  state_nxt = B_SPAN_LD;
      B_SPAN_LD: begin
        if (ls_q_r < rs_q_r) state_nxt = B_FILL;
        else state_nxt = row_last ? B_IDLE : B_SPAN_RD;
      end
      B_FILL: begin
        if (({1'b0, x_r} + 1'b1) == {1'b0, xr_r}) state_nxt = row_last ? B_IDLE : B_SPAN_RD;
      end
      B_CNT: begin
        if ((({1'b0, x_r} + 1'b1) == w_r) && (({1'b0, y_r} + 1'b1) == h_r)) state_nxt = B_CNT_DRAIN;
      end
      B_CNT_DRAIN: state_nxt = B_DIV;
      B_DIV: if (k_r == 5'd16) state_nxt = B_OUT;
      B_OUT: if (!out_vld_r || out_tready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      init_done_r <= 1'b0;
      clr_r <= '0;
      inc_vld_r <= 1'b0;
      cnt_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inc_vld_r <= state_r == B_FILL;
      cnt_vld_r <= state_r == B_CNT;
      if (state_r == B_CLEAR) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) init_done_r <= 1'b1;
      end else begin
        clr_r <= '0;
      end
      if (state_r == B_OUT && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (gw_en) grid_mem[gw_addr] <= gw_data;
    gr_q_r <= grid_mem[gr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en && sw_left) lspan_mem[sw_addr] <= sw_data;
    if (sw_en && !sw_left) rspan_mem[sw_addr] <= sw_data;
    ls_q_r <= lspan_mem[y_r];
    rs_q_r <= rspan_mem[y_r];
  end

  always_ff @(posedge clk) begin
    inc_addr_r <= gr_addr;
    if (cnt_vld_r) begin
      fill_r <= fill_r + NW'(gr_q_r != 2'd0);
      over_r <= over_r + NW'(gr_q_r == 2'd2);
    end
    case (state_r)
      B_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          px_r[i] <= cmd_px[i];
          py_r[i] <= cmd_py[i];
        end
        edge_r <= cmd_edge;
        ymin_r <= cmd_ymin;
        ymax_r <= cmd_ymax;
        ei_r <= '0;
        x_r <= '0;
        y_r <= '0;
        w_r <= wc;
        h_r <= hc;
        area_r <= NW'(wc * hc);
        fill_r <= '0;
        over_r <= '0;
        k_r <= '0;
      end
      B_EDGE_START: begin
        if (ei_r == 2'd3) begin
          y_r <= ymin_r;
        end else begin
          ei_r <= edge_r.vld[ei_r] ? ei_r : ei_r + 2'd1;
          x_r <= xa;
          y_r <= ya;
          xb_r <= xb;
          yb_r <= yb;
          dx_r <= dxa;
          dy_r <= dy;
          sx_neg_r <= sneg;
          left_r <= edge_r.left[ei_r];
          e_r <= e0;
        end
      end
      B_EDGE_ROW: begin
        y_r <= y_r + 1'b1;
        e_r <= e_r - $signed(EW'({dx_r, 1'b0}));
      end
      B_EDGE_STEP: begin
        if (e_r[EW-1]) begin
          x_r <= sx_neg_r ? x_r - 1'b1 : x_r + 1'b1;
          e_r <= e_r + $signed(EW'({dy_r, 1'b0}));
        end
      end
      B_EDGE_END: ei_r <= ei_r + 2'd1;
      B_SPAN_LD: begin
        x_r <= ls_q_r;
        xr_r <= rs_q_r;
        if (!(ls_q_r < rs_q_r)) y_r <= y_r + 1'b1;
      end
      B_FILL: begin
        x_r <= x_r + 1'b1;
        if (({1'b0, x_r} + 1'b1) == {1'b0, xr_r}) y_r <= y_r + 1'b1;
      end
      B_CNT: begin
        if (({1'b0, x_r} + 1'b1) == w_r) begin
          x_r <= '0;
          y_r <= y_r + 1'b1;
        end else begin
          x_r <= x_r + 1'b1;
        end
      end
      B_DIV: begin
        k_r <= k_r + 5'd1;
        remf_r <= ge_f ? NW'(rin_f - {1'b0, area_r}) : NW'(rin_f);
        remo_r <= ge_o ? NW'(rin_o - {1'b0, area_r}) : NW'(rin_o);
        qf_r <= {qf_r[15:0], ge_f};
        qo_r <= {qo_r[15:0], ge_o};
      end
      B_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_data_r <= {4'b0,
                         (area_r == '0) ? 17'd0 : qo_r,
                         (area_r == '0) ? 17'd0 : qf_r,
                         21'(over_r),
                         21'(fill_r)};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/triangle_coverage_rasterizer.sv -----
// ----------------------------------------------------------------------------
// triangle_coverage_rasterizer
// triangle coverage counting on a square pixel grid with fill statistics
//
// channel  | direction | accepted when
// in_*     | input     | in_tvalid and in_tready
// out_*    | output    | out_tvalid and out_tready
// cfg_*    | apb       | psel, penable, pwrite and pready (writes)
//
// a triangle is mapped in the front (six vertex mappings, each a subtract,
// multiply and clamp step through one shared multiplier pair); the back walks
// each edge row by row with a step state per x step, then reads each span row
// and fills its covered pixels one after another; clear and finish walk the
// grid (finish w*h pixels, then a drain and a division), bound by the one grid
// memory; reset starts with a clearing pass over the grid with in_tready low
// ----------------------------------------------------------------------------
module triangle_coverage_rasterizer import tcr_pkg::*; #(
  parameter int GRID_SIZE = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // vertex_a_u, vertex_a_v, vertex_b_u, vertex_b_v, vertex_c_u, vertex_c_v
  input  logic [1:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // filled_pixels, overlapped_pixels, fill_fraction, overlap_fraction
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

`include "assert_macros.svh"

  localparam int CW = $clog2(GRID_SIZE);
  localparam int CMD_W = 8 + 8 * CW;

  logic [31:0] origin_u_r, origin_v_r, scale_r;
  logic [10:0] act_w_r, act_h_r;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  logic init_done, q_push, q_pop;
  q_stat_t q_stat;
  act_t f_kind, b_kind;
  edge_ctl_t f_edge, b_edge;
  logic [2:0][CW-1:0] f_px, f_py, b_px, b_py;
  logic [CW-1:0] f_ymin, f_ymax, b_ymin, b_ymax;
  logic [1:0] b_kind_bits;
  logic [CMD_W-1:0] cmd_wr, cmd_rd;

  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_u_r <= '0;
      origin_v_r <= '0;
      scale_r <= SCALE_RESET;
      act_w_r <= ACT_SIZE_RESET;
      act_h_r <= ACT_SIZE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_ORIGIN_U:   origin_u_r <= cfg_pwdata;
        CFG_ORIGIN_V:   origin_v_r <= cfg_pwdata;
        CFG_SCALE:      scale_r <= cfg_pwdata;
        CFG_ACT_WIDTH:  act_w_r <= cfg_pwdata[10:0];
        CFG_ACT_HEIGHT: act_h_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_ORIGIN_U:   cfg_prdata = origin_u_r;
      CFG_ORIGIN_V:   cfg_prdata = origin_v_r;
      CFG_SCALE:      cfg_prdata = scale_r;
      CFG_ACT_WIDTH:  cfg_prdata = {21'b0, act_w_r};
      CFG_ACT_HEIGHT: cfg_prdata = {21'b0, act_h_r};
      default:        cfg_prdata = '0;
    endcase
  end

  tcr_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .init_done   (init_done),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .origin_u    (origin_u_r),
    .origin_v    (origin_v_r),
    .pixel_scale (scale_r),
    .q_full      (q_stat.full),
    .push        (q_push),
    .cmd_kind    (f_kind),
    .cmd_edge    (f_edge),
    .cmd_px      (f_px),
    .cmd_py      (f_py),
    .cmd_ymin    (f_ymin),
    .cmd_ymax    (f_ymax)
  );

  assign cmd_wr = {f_kind, f_edge, f_px, f_py, f_ymin, f_ymax};

  tcr_queue #(.W(CMD_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (cmd_wr),
    .pop   (q_pop),
    .rdata (cmd_rd),
    .stat  (q_stat)
  );

  assign {b_kind_bits, b_edge, b_px, b_py, b_ymin, b_ymax} = cmd_rd;
  assign b_kind = act_t'(b_kind_bits);

  tcr_back #(.GRID_SIZE(GRID_SIZE)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .init_done     (init_done),
    .q_empty       (q_stat.empty),
    .pop           (q_pop),
    .cmd_kind      (b_kind),
    .cmd_edge      (b_edge),
    .cmd_px        (b_px),
    .cmd_py        (b_py),
    .cmd_ymin      (b_ymin),
    .cmd_ymax      (b_ymax),
    .active_width  (act_w_r),
    .active_height (act_h_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

  `TCR_ASSERT_SAME(a_ready_after_init, clk, rst_n, in_tready, init_done, "ready during clearing pass")
  `TCR_ASSERT_SAME(a_no_push_full, clk, rst_n, q_push, !q_stat.full, "push into full queue")
  `TCR_ASSERT_SAME(a_no_pop_empty, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
  `TCR_ASSERT_NEXT(a_push_fills, clk, rst_n, q_push && q_stat.empty, !q_stat.empty, "pushed item lost")

endmodule
